// File: rtl/tdtd_pkg.sv
// shared types and constants for the touch debounce and tap detector
package tdtd_pkg;

  localparam int unsigned READING_W = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DEB_W     = 10;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  // reset values of the configuration registers
  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 10'd50;
  localparam logic [15:0]      TAP_MIN_RST   = 16'd50;
  localparam logic [15:0]      TAP_MAX_RST   = 16'd500;
  localparam logic [THR_W-1:0] THR_INIT_RST  = 16'd40;
  localparam logic [THR_W-1:0] THR_FLOOR_RST = 16'd20;
  localparam logic [THR_W-1:0] THR_CEIL_RST  = 16'd60;

  // floor(x / 5) as (x * DIV5_MUL) >> DIV5_SHIFT, exact for x < 2^18
  localparam int unsigned      DIV5_SHIFT = 21;
  localparam logic [18:0]      DIV5_MUL   = 19'd419431;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_TAP_MIN   = 3'd1,
    CFG_TAP_MAX   = 3'd2,
    CFG_THR_INIT  = 3'd3,
    CFG_THR_FLOOR = 3'd4,
    CFG_THR_CEIL  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_SENSE = 1'b0,
    CMD_CALIB = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                 cmd;
    logic [READING_W-1:0] reading;
    logic [TIME_W-1:0]    now_ms;
  } in_word_t;

  typedef struct packed {
    logic             touched;
    logic             tap;
    logic [THR_W-1:0] threshold;
    logic             calibration_done;
  } out_word_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic [15:0]      tap_min_ms;
    logic [15:0]      tap_max_ms;
  } sense_cfg_t;

  typedef struct packed {
    logic             touched;
    logic             tap;
    logic [THR_W-1:0] threshold;
    logic             done;
    logic [THR_W-1:0] mean;
  } pipe_word_t;

endpackage

// File: rtl/tdtd_sense.sv
// debounce state and tap timing for sense words
module tdtd_sense import tdtd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [READING_W-1:0] reading_i,
  input  logic [TIME_W-1:0]    now_i,
  input  logic [THR_W-1:0]     threshold_i,
  input  sense_cfg_t           cfg_i,
  output logic                 touched_o,
  output logic                 tap_o
);

  logic              raw_q, raw_d;
  logic              stable_q, stable_d;
  logic [TIME_W-1:0] flip_time_q, flip_time_d;
  logic [TIME_W-1:0] press_time_q, press_time_d;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] held;
  logic              seen;
  logic              settled;
  logic              tap_d;

  always_comb begin
    seen         = reading_i < threshold_i;
    raw_d        = seen;
    flip_time_d  = (seen != raw_q) ? now_i : flip_time_q;
    elapsed      = now_i - flip_time_d;
    settled      = elapsed >= {{(TIME_W-DEB_W){1'b0}}, cfg_i.debounce_ms};
    held         = now_i - press_time_q;
    stable_d     = stable_q;
    press_time_d = press_time_q;
    tap_d        = 1'b0;
    if (settled) begin
      stable_d = seen;
      // release after a press of tap length
      if (stable_q && !seen) begin
        tap_d = (held >= {16'd0, cfg_i.tap_min_ms}) && (held <= {16'd0, cfg_i.tap_max_ms});
      end
      if (!stable_q && seen) begin
        press_time_d = now_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q        <= 1'b0;
      stable_q     <= 1'b0;
      flip_time_q  <= '0;
      press_time_q <= '0;
    end else if (en_i) begin
      raw_q        <= raw_d;
      stable_q     <= stable_d;
      flip_time_q  <= flip_time_d;
      press_time_q <= press_time_d;
    end
  end

  assign touched_o = en_i ? stable_d : stable_q;
  assign tap_o     = en_i & tap_d;

endmodule

// File: rtl/tdtd_calib.sv
// calibration accumulator and mean of the collected readings
module tdtd_calib import tdtd_pkg::*; #(
  parameter int unsigned CALIB_SAMPLES = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [READING_W-1:0] reading_i,
  output logic                 done_o,
  output logic [THR_W-1:0]     mean_o
);

  // floor(s / N) as (s * RECIP) >> RECIP_SHIFT, exact for s < 2^20 and N < 16
  localparam int unsigned RECIP_SHIFT = SUM_W + CNT_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / CALIB_SAMPLES + 64'd1);
  localparam logic [CNT_W-1:0] SAMPLES = CNT_W'(CALIB_SAMPLES);

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [PROD_W-1:0] prod;
  logic              full;

  always_comb begin
    sum_d   = sum_q + {{(SUM_W-READING_W){1'b0}}, reading_i};
    count_d = count_q + CNT_W'(1);
    full    = count_d >= SAMPLES;
    prod    = {{RECIP_W{1'b0}}, sum_d} * {{SUM_W{1'b0}}, RECIP};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (en_i) begin
      if (full) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_d;
      end
    end
  end

  assign done_o = en_i & full;
  assign mean_o = prod[RECIP_SHIFT +: THR_W];

endmodule

// File: rtl/tdtd_thresh.sv
// active threshold register and the 3/5 scaling with clamp
module tdtd_thresh import tdtd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [THR_W-1:0] load_value_i,
  input  logic             update_i,
  input  logic [THR_W-1:0] mean_i,
  input  logic [THR_W-1:0] floor_i,
  input  logic [THR_W-1:0] ceil_i,
  output logic [THR_W-1:0] threshold_o,
  output logic [THR_W-1:0] calc_o
);

  logic [THR_W-1:0] active_q;
  logic [17:0]      triple;
  logic [36:0]      prod;
  logic [THR_W-1:0] scaled;
  logic [THR_W-1:0] clamped;

  always_comb begin
    triple  = {1'b0, mean_i, 1'b0} + {2'b00, mean_i};
    prod    = {19'd0, triple} * {18'd0, DIV5_MUL};
    scaled  = prod[DIV5_SHIFT +: THR_W];
    clamped = scaled;
    // floor first, ceiling wins when they cross
    if (clamped < floor_i) begin
      clamped = floor_i;
    end
    if (clamped > ceil_i) begin
      clamped = ceil_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= THR_INIT_RST;
    end else if (load_i) begin
      active_q <= load_value_i;
    end else if (update_i) begin
      active_q <= clamped;
    end
  end

  assign threshold_o = active_q;
  assign calc_o      = clamped;

endmodule

// File: rtl/touch_debounce_tap_detector_top.sv
// top level of the touch debounce and tap detector
//
// input channel: in_valid_i / in_ready_o carry one word with cmd, reading and
// now_ms. cmd selects a sense sample (debounce and tap timing) or a
// calibration sample (accumulate, then rescale the threshold).
// output channel: out_valid_o / out_ready_i return exactly one word per input
// word, in order: touched, tap pulse, threshold in force, calibration_done.
// config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
// writing threshold_initial also loads the active threshold.
// path: an accepted word goes from the input register through the state update
// stage and the threshold stage into the output register behind out_valid_o.
// throughput: one word per cycle with no gaps while out_ready_i stays high; a
// word right behind a word that completes a calibration run takes the new
// threshold straight from the threshold stage.
// reset: all debounce, calibration and handshake state clears and the
// configuration registers take their default values; no clearing pass.
// stall: while out_ready_i is low the output word holds, and the two inner
// stages keep filling so that up to three words are held before in_ready_o
// drops.
module touch_debounce_tap_detector_top import tdtd_pkg::*; #(
  parameter int unsigned CALIB_SAMPLES = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // configuration registers
  sense_cfg_t       sense_cfg_q;
  logic [THR_W-1:0] floor_q;
  logic [THR_W-1:0] ceil_q;
  logic             thr_load;

  // pipeline
  logic       in_valid_q;
  in_word_t   in_q;
  logic       pipe_valid_q;
  pipe_word_t pipe_q, pipe_d;
  logic       out_valid_q;
  out_word_t  out_q, out_d;

  logic out_adv;
  logic pipe_fire;
  logic pipe_free;
  logic hazard;
  logic s1_fire;
  logic sense_en;
  logic calib_en;

  logic             touched;
  logic             tap;
  logic             calib_done;
  logic [THR_W-1:0] mean;
  logic [THR_W-1:0] active_thr;
  logic [THR_W-1:0] calc_thr;
  logic [THR_W-1:0] cur_thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_cfg_q.debounce_ms <= DEBOUNCE_RST;
      sense_cfg_q.tap_min_ms  <= TAP_MIN_RST;
      sense_cfg_q.tap_max_ms  <= TAP_MAX_RST;
      floor_q                 <= THR_FLOOR_RST;
      ceil_q                  <= THR_CEIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:  sense_cfg_q.debounce_ms <= cfg_wdata_i[DEB_W-1:0];
        CFG_TAP_MIN:   sense_cfg_q.tap_min_ms  <= cfg_wdata_i;
        CFG_TAP_MAX:   sense_cfg_q.tap_max_ms  <= cfg_wdata_i;
        CFG_THR_FLOOR: floor_q                 <= cfg_wdata_i;
        CFG_THR_CEIL:  ceil_q                  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign thr_load = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_THR_INIT);

  // handshake and stage control
  always_comb begin
    out_adv    = !out_valid_q || out_ready_i;
    pipe_fire  = pipe_valid_q && out_adv;
    pipe_free  = !pipe_valid_q || out_adv;
    // a finished calibration ahead has not reached the threshold register yet
    hazard     = pipe_valid_q && pipe_q.done;
    cur_thr    = hazard ? calc_thr : active_thr;
    s1_fire    = in_valid_q && pipe_free;
    in_ready_o = !in_valid_q || s1_fire;
    sense_en   = s1_fire && (cmd_e'(in_q.cmd) == CMD_SENSE);
    calib_en   = s1_fire && (cmd_e'(in_q.cmd) == CMD_CALIB);
  end

  tdtd_sense u_sense (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (sense_en),
    .reading_i   (in_q.reading),
    .now_i       (in_q.now_ms),
    .threshold_i (cur_thr),
    .cfg_i       (sense_cfg_q),
    .touched_o   (touched),
    .tap_o       (tap)
  );

  tdtd_calib #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_calib (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (calib_en),
    .reading_i (in_q.reading),
    .done_o    (calib_done),
    .mean_o    (mean)
  );

  tdtd_thresh u_thresh (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (thr_load),
    .load_value_i (cfg_wdata_i),
    .update_i     (pipe_fire && pipe_q.done),
    .mean_i       (pipe_q.mean),
    .floor_i      (floor_q),
    .ceil_i       (ceil_q),
    .threshold_o  (active_thr),
    .calc_o       (calc_thr)
  );

  always_comb begin
    pipe_d.touched   = touched;
    pipe_d.tap       = tap;
    pipe_d.threshold = cur_thr;
    pipe_d.done      = calib_done;
    pipe_d.mean      = mean;

    out_d.touched          = pipe_q.touched;
    out_d.tap              = pipe_q.tap;
    out_d.threshold        = pipe_q.done ? calc_thr : pipe_q.threshold;
    out_d.calibration_done = pipe_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (s1_fire) begin
        in_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        pipe_valid_q <= 1'b1;
      end else if (pipe_fire) begin
        pipe_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= pipe_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (s1_fire) begin
      pipe_q <= pipe_d;
    end
    if (pipe_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/tb_top.sv
// self-checking bench for the touch debounce and tap detector
`timescale 1ns / 1ps

module tb_top;
  import tdtd_pkg::*;

  localparam int CALIB_N     = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES      = 6;

  typedef struct packed {
    logic [15:0] deb;
    logic [15:0] tmin;
    logic [15:0] tmax;
    logic [15:0] tinit;
    logic [15:0] tfloor;
    logic [15:0] tceil;
  } cfg_set_t;

  typedef struct packed {
    in_word_t  word;
    logic      fixed;
    out_word_t want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // register copies and detector state as the bench sees them
  logic [DEB_W-1:0] deb_ms     = DEBOUNCE_RST;
  logic [15:0]      tap_min    = TAP_MIN_RST;
  logic [15:0]      tap_max    = TAP_MAX_RST;
  logic [THR_W-1:0] thr_init   = THR_INIT_RST;
  logic [THR_W-1:0] thr_floor  = THR_FLOOR_RST;
  logic [THR_W-1:0] thr_ceil   = THR_CEIL_RST;
  logic [THR_W-1:0] act_thr    = THR_INIT_RST;
  logic             raw_st     = 1'b0;
  logic             stable_st  = 1'b0;
  logic [31:0]      flip_ms    = '0;
  logic [31:0]      press_ms   = '0;
  logic [SUM_W-1:0] cal_sum    = '0;
  logic [CNT_W-1:0] cal_cnt    = '0;

  out_word_t   pending_outcomes[$];
  row_t        directed_rows[$];
  out_word_t   got_want;
  int          errs = 0;
  int          cycles = 0;
  int          send_idle = 31;
  int          recv_idle = 46;

  // stimulus shaping state
  logic [31:0] cur_ms = '0;
  logic        want_touch = 1'b0;
  int unsigned seg_left = 0;
  int unsigned seg_step = 1;
  int unsigned cal_left = 0;

  touch_debounce_tap_detector_top #(
    .CALIB_SAMPLES(CALIB_N)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic out_word_t touch_outcome(input in_word_t w);
    out_word_t   r;
    logic        seen;
    logic        was;
    logic [31:0] held;
    logic [31:0] mean;
    logic [31:0] thr;
    r = '0;
    if (w.cmd == CMD_SENSE) begin
      seen = (w.reading < act_thr);
      if (seen != raw_st) begin
        flip_ms = w.now_ms;
        raw_st = seen;
      end
      if (w.now_ms - flip_ms >= {22'd0, deb_ms}) begin
        was = stable_st;
        stable_st = raw_st;
        if (was && !stable_st) begin
          held = w.now_ms - press_ms;
          if (held >= {16'd0, tap_min} && held <= {16'd0, tap_max}) r.tap = 1'b1;
        end
        if (!was && stable_st) press_ms = w.now_ms;
      end
    end else begin
      cal_sum = cal_sum + w.reading;
      cal_cnt = cal_cnt + 1'b1;
      if (cal_cnt >= CALIB_N) begin
        mean = cal_sum / CALIB_N;
        thr = (mean * 3) / 5;
        // floor first, so the ceiling wins when they cross
        if (thr < {16'd0, thr_floor}) thr = {16'd0, thr_floor};
        if (thr > {16'd0, thr_ceil}) thr = {16'd0, thr_ceil};
        act_thr = thr[15:0];
        cal_sum = '0;
        cal_cnt = '0;
        r.calibration_done = 1'b1;
      end
    end
    r.touched = stable_st;
    r.threshold = act_thr;
    return r;
  endfunction

  function automatic row_t row(input cmd_e cmd, input logic [15:0] rd, input logic [31:0] t,
                               input logic fixed, input out_word_t want);
    row_t r;
    r.word.cmd = cmd;
    r.word.reading = rd;
    r.word.now_ms = t;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        errs++;
        $display("%0t: word expected none, got %h", $time, out_data);
      end else begin
        got_want = pending_outcomes.pop_front();
        check_field("touched", got_want.touched, out_data.touched);
        check_field("tap", got_want.tap, out_data.tap);
        check_field("threshold", got_want.threshold, out_data.threshold);
        check_field("calibration_done", got_want.calibration_done,
                    out_data.calibration_done);
      end
    end
  end

  task automatic send_word(input in_word_t w, input logic fixed, input out_word_t want);
    out_word_t calc;
    @(negedge clk);
    while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    calc = touch_outcome(w);
    pending_outcomes.push_back(fixed ? want : calc);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE:  deb_ms = val[DEB_W-1:0];
      CFG_TAP_MIN:   tap_min = val;
      CFG_TAP_MAX:   tap_max = val;
      CFG_THR_INIT: begin
        thr_init = val;
        act_thr = val;
      end
      CFG_THR_FLOOR: thr_floor = val;
      CFG_THR_CEIL:  thr_ceil = val;
      default: ;
    endcase
  endtask

  task automatic load_plan(input cfg_set_t s);
    write_reg(CFG_DEBOUNCE, s.deb);
    write_reg(CFG_TAP_MIN, s.tmin);
    write_reg(CFG_TAP_MAX, s.tmax);
    write_reg(CFG_THR_INIT, s.tinit);
    write_reg(CFG_THR_FLOOR, s.tfloor);
    write_reg(CFG_THR_CEIL, s.tceil);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_set_t plan(input int p);
    case (p)
      0:       plan = {16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535};
      1:       plan = {16'd1000, 16'd100, 16'd2000, 16'd30000, 16'd20, 16'd60};
      2:       plan = {16'd10, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd300};
      3:       plan = {16'd20, 16'd20, 16'd200, 16'd32768, 16'd1000, 16'd50000};
      4:       plan = {16'd1, 16'd5, 16'd60, 16'd40, 16'd20, 16'd60};
      default: plan = {16'd513, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0};
    endcase
  endfunction

  // mostly press and release segments sized around the tap window, with
  // bounces, calibration bursts and some fully random words mixed in
  task automatic next_word(output in_word_t w);
    int unsigned dur;
    int unsigned step;
    int unsigned thr_i;
    logic        touch;
    w = '0;
    thr_i = act_thr;
    if (cal_left == 0 && $urandom_range(0, 99) < 4) cal_left = $urandom_range(3, 12);
    if (cal_left > 0) begin
      cal_left--;
      w.cmd = CMD_CALIB;
      w.reading = $urandom_range(0, 1) ? 16'($urandom_range(0, 150))
                                       : 16'($urandom_range(0, 65535));
      w.now_ms = $urandom;
    end else if ($urandom_range(0, 99) < 6) begin
      cur_ms = $urandom_range(0, 1) ? $urandom : cur_ms + $urandom_range(0, 3);
      w.cmd = CMD_SENSE;
      w.reading = 16'($urandom_range(0, 65535));
      w.now_ms = cur_ms;
    end else begin
      if (seg_left == 0) begin
        want_touch = !want_touch;
        case ($urandom_range(0, 3))
          0:       dur = deb_ms + tap_min;
          1:       dur = deb_ms + tap_max;
          2:       dur = deb_ms + $urandom_range(0, tap_max);
          default: dur = $urandom_range(0, deb_ms + 1);
        endcase
        seg_left = $urandom_range(2, 6);
        seg_step = dur / seg_left + 1;
      end
      seg_left--;
      step = seg_step - $urandom_range(0, seg_step / 8);
      cur_ms = cur_ms + step;
      touch = want_touch ^ ($urandom_range(0, 9) == 0);
      w.cmd = CMD_SENSE;
      w.now_ms = cur_ms;
      if (touch && thr_i > 0)
        w.reading = ($urandom_range(0, 2) == 0) ? 16'(thr_i - 1)
                                                : 16'($urandom_range(0, thr_i - 1));
      else if (!touch)
        w.reading = ($urandom_range(0, 2) == 0) ? 16'(thr_i)
                                                : 16'($urandom_range(thr_i, 65535));
      else
        w.reading = 16'($urandom_range(0, 65535));
    end
  endtask

  initial begin
    in_word_t w;
    directed_rows.push_back(row(CMD_SENSE, 16'd65535, 32'd0, 1'b1, {1'b0, 1'b0, 16'd40, 1'b0}));
    directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'd10, 1'b1, {1'b0, 1'b0, 16'd40, 1'b0}));
    directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'd60, 1'b1, {1'b1, 1'b0, 16'd40, 1'b0}));
    directed_rows.push_back(row(CMD_SENSE, 16'd65535, 32'd200, 1'b1,
                                {1'b1, 1'b0, 16'd40, 1'b0}));
    directed_rows.push_back(row(CMD_SENSE, 16'd65535, 32'd250, 1'b1,
                                {1'b0, 1'b1, 16'd40, 1'b0}));
    // threshold boundary and one short of the debounce time
    directed_rows.push_back(row(CMD_SENSE, 16'd39, 32'd310, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd39, 32'd359, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd39, 32'd360, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd40, 32'd370, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd40, 32'd420, 1'b0, '0));
    // press too long for a tap
    directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'd1000, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'd1050, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd65535, 32'd1600, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd65535, 32'd1650, 1'b0, '0));
    // debounce across the timestamp wrap
    directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'hFFFF_FFF0, 1'b0, '0));
    directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'h0000_0022, 1'b0, '0));
    // full-scale calibration run with a sense word in the middle
    for (int i = 0; i < CALIB_N; i++) begin
      if (i == CALIB_N / 2) directed_rows.push_back(row(CMD_SENSE, 16'd0, 32'h40, 1'b0, '0));
      directed_rows.push_back(row(CMD_CALIB, 16'd65535, 32'hFFFF_FFFF, i == CALIB_N - 1,
                                  {1'b1, 1'b0, 16'd60, 1'b1}));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < directed_rows.size(); i++)
      send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_plan(plan(p));
      case (p / 2)
        0: begin
          send_idle = 31;
          recv_idle = 46;
        end
        1: begin
          send_idle = 46;
          recv_idle = 31;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // let the pipeline drain completely once mid-phase
        if (p == 2 && i == PHASE_ITEMS / 2) settle();
        next_word(w);
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tdtd_pkg.sv
rtl/tdtd_sense.sv
rtl/tdtd_calib.sv
rtl/tdtd_thresh.sv
rtl/touch_debounce_tap_detector_top.sv
tb/tb_top.sv
